/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* hw/rtl/vtp_pkg.sv */
// Shared constants and types for the vertex transform and project unit.
`timescale 1ns / 1ps
package vtp_pkg;
	localparam int COORD_W_DEF  = 32;
	localparam int COEF_W_DEF   = 20;
	localparam int SCREEN_W_DEF = 16;
	localparam int FRAC_BITS    = 16;
	localparam int DIST_W       = 12;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_W   = 6;
	localparam logic signed [31:0] NEAR_PLANE = 32'sd327680;
	localparam logic [31:0] FAR_RESET = 32'd65536000;
	localparam logic [DIST_W-1:0] DIST_RESET = 12'd256;
	localparam int MIN_Z = 7;

	typedef enum logic [2:0] {
		REG_ROW_X    = 3'd0,
		REG_ROW_Y    = 3'd1,
		REG_ROW_Z    = 3'd2,
		REG_SHIFT_XY = 3'd3,
		REG_SHIFT_Z  = 3'd4,
		REG_DIST     = 3'd5,
		REG_FAR      = 3'd6,
		REG_Z_OFF    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [63:0]       row_x;
		logic [63:0]       row_y;
		logic [63:0]       row_z;
		logic [63:0]       shift_xy;
		logic [31:0]       shift_z;
		logic [DIST_W-1:0] view_dist;
		logic [31:0]       far_lim;
		logic [31:0]       z_off;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic visible;
		logic last;
	} flags_t;
endpackage

/* hw/rtl/vtp_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module vtp_regs import vtp_pkg::*; #(
	parameter int COEF_WIDTH = COEF_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	localparam int ROW_W = 3 * COEF_WIDTH;

	logic [ROW_W-1:0]  row_x_q, row_y_q, row_z_q;
	logic [63:0]       shift_xy_q;
	logic [31:0]       shift_z_q, far_q, z_off_q;
	logic [DIST_W-1:0] dist_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q    <= ROW_W'(1) << FRAC_BITS;
			row_y_q    <= ROW_W'(1) << (COEF_WIDTH + FRAC_BITS);
			row_z_q    <= ROW_W'(1) << (2 * COEF_WIDTH + FRAC_BITS);
			shift_xy_q <= '0;
			shift_z_q  <= '0;
			dist_q     <= DIST_RESET;
			far_q      <= FAR_RESET;
			z_off_q    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ROW_X:    row_x_q    <= pwdata[ROW_W-1:0];
				REG_ROW_Y:    row_y_q    <= pwdata[ROW_W-1:0];
				REG_ROW_Z:    row_z_q    <= pwdata[ROW_W-1:0];
				REG_SHIFT_XY: shift_xy_q <= pwdata;
				REG_SHIFT_Z:  shift_z_q  <= pwdata[31:0];
				REG_DIST:     dist_q     <= pwdata[DIST_W-1:0];
				REG_FAR:      far_q      <= pwdata[31:0];
				REG_Z_OFF:    z_off_q    <= pwdata[31:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW_X:    prdata = 64'(row_x_q);
			REG_ROW_Y:    prdata = 64'(row_y_q);
			REG_ROW_Z:    prdata = 64'(row_z_q);
			REG_SHIFT_XY: prdata = shift_xy_q;
			REG_SHIFT_Z:  prdata = 64'(shift_z_q);
			REG_DIST:     prdata = 64'(dist_q);
			REG_FAR:      prdata = 64'(far_q);
			REG_Z_OFF:    prdata = 64'(z_off_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.row_x     = 64'(row_x_q);
	assign cfg.row_y     = 64'(row_y_q);
	assign cfg.row_z     = 64'(row_z_q);
	assign cfg.shift_xy  = shift_xy_q;
	assign cfg.shift_z   = shift_z_q;
	assign cfg.view_dist = dist_q;
	assign cfg.far_lim   = far_q;
	assign cfg.z_off     = z_off_q;
endmodule

/* hw/rtl/vtp_xform.sv */
// Visibility test and affine transform: products, then sum, truncate and saturate.
`timescale 1ns / 1ps
module vtp_xform import vtp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_W_DEF,
	parameter int COEF_WIDTH  = COEF_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic                   in_last,
	input  logic [COORD_WIDTH-1:0] mx,
	input  logic [COORD_WIDTH-1:0] my,
	input  logic [COORD_WIDTH-1:0] mz,
	input  cfg_t                   cfg,
	output flags_t                 flags_s2,
	output logic [COORD_WIDTH-1:0] wx_s2,
	output logic [COORD_WIDTH-1:0] wy_s2,
	output logic [COORD_WIDTH-1:0] wz_s2
);
	localparam int C  = COORD_WIDTH;
	localparam int PW = COORD_WIDTH + COEF_WIDTH;
	localparam int EW = ((C > 32) ? C : 32) + 1;
	localparam int AW = ((PW > 48) ? PW : 48) + 2;

	logic signed [C-1:0]          m [3];
	logic signed [COEF_WIDTH-1:0] cf [3][3];
	logic signed [PW-1:0]         prod [3][3];
	logic signed [PW-1:0]         prod_s1 [3][3];
	logic signed [31:0]           shift [3];
	logic signed [31:0]           shift_s1 [3];
	logic signed [EW-1:0]         ez, far_e;
	logic                         vis;
	flags_t                       flags_s1;
	logic signed [AW-1:0]         acc [3];
	logic signed [AW-1:0]         sh [3];
	logic [C-1:0]                 wsat [3];

	assign m[0] = $signed(mx);
	assign m[1] = $signed(my);
	assign m[2] = $signed(mz);

	assign shift[0] = $signed(cfg.shift_xy[31:0]);
	assign shift[1] = $signed(cfg.shift_xy[63:32]);
	assign shift[2] = $signed(cfg.shift_z);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cf[0][k] = $signed(cfg.row_x[k*COEF_WIDTH +: COEF_WIDTH]);
			cf[1][k] = $signed(cfg.row_y[k*COEF_WIDTH +: COEF_WIDTH]);
			cf[2][k] = $signed(cfg.row_z[k*COEF_WIDTH +: COEF_WIDTH]);
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod[r][k] = PW'(cf[r][k]) * PW'(m[k]);
			end
		end
	end

	assign ez    = EW'(m[2]) + EW'($signed(cfg.z_off));
	assign far_e = EW'($signed(cfg.far_lim));
	assign vis   = (ez > EW'(NEAR_PLANE)) && (ez <= far_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
		end else if (adv) begin
			flags_s1 <= '{valid: in_valid, visible: vis, last: in_last};
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= prod;
			shift_s1 <= shift;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = AW'(prod_s1[r][0]) + AW'(prod_s1[r][1]) + AW'(prod_s1[r][2])
				+ (AW'(shift_s1[r]) <<< FRAC_BITS);
			sh[r] = acc[r] >>> FRAC_BITS;
			if (!sh[r][AW-1] && (|sh[r][AW-2:C-1]))
				wsat[r] = {1'b0, {(C-1){1'b1}}};
			else if (sh[r][AW-1] && !(&sh[r][AW-2:C-1]))
				wsat[r] = {1'b1, {(C-1){1'b0}}};
			else
				wsat[r] = sh[r][C-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s2 <= wsat[0];
			wy_s2 <= wsat[1];
			wz_s2 <= wsat[2];
		end
	end
endmodule

/* hw/rtl/vtp_proj.sv */
// Perspective projection: distance multiply, then a one-bit-per-stage divider.
`timescale 1ns / 1ps
module vtp_proj import vtp_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_W_DEF,
	parameter int SCREEN_WIDTH = SCREEN_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  flags_t                  flags_in,
	input  logic [COORD_WIDTH-1:0]  wx,
	input  logic [COORD_WIDTH-1:0]  wy,
	input  logic [COORD_WIDTH-1:0]  wz,
	input  logic [DIST_W-1:0]       view_dist,
	output flags_t                  flags_o,
	output logic [COORD_WIDTH-1:0]  wx_o,
	output logic [COORD_WIDTH-1:0]  wy_o,
	output logic [COORD_WIDTH-1:0]  wz_o,
	output logic [SCREEN_WIDTH-1:0] sx_o,
	output logic [SCREEN_WIDTH-1:0] sy_o
);
	localparam int C  = COORD_WIDTH;
	localparam int SW = SCREEN_WIDTH;
	localparam int NW = C + DIST_W + 1;
	localparam int RW = C + SW + DIST_W + 1;
	localparam int QW = SW - 1;
	localparam int WW = 3 * C;

	flags_t               flags_s3;
	logic [WW-1:0]        world_s3;
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic [C-1:0]         z_s3;
	logic signed [NW-1:0] nx, ny;
	logic [C-1:0]         zc;

	flags_t        flags_sd [SW];
	logic [WW-1:0] world_sd [SW];
	logic [C-1:0]  z_sd [SW];
	logic [RW-1:0] remx_sd [SW];
	logic [RW-1:0] remy_sd [SW];
	logic [QW-1:0] qx_sd [SW];
	logic [QW-1:0] qy_sd [SW];
	logic          negx_sd [SW];
	logic          negy_sd [SW];
	logic          ovfx_sd [SW];
	logic          ovfy_sd [SW];

	logic [NW-1:0] magx, magy;
	logic [RW-1:0] zlim;
	logic [SW-1:0] scx, scy;

	assign nx = $signed({1'b0, view_dist}) * NW'($signed(wx));
	assign ny = $signed({1'b0, view_dist}) * NW'($signed(wy));
	assign zc = ($signed(wz) <= 0) ? C'(MIN_Z) : wz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s3    <= '0;
			flags_sd[0] <= '0;
		end else if (adv) begin
			flags_s3    <= flags_in;
			flags_sd[0] <= flags_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			world_s3 <= {wz, wy, wx};
			nx_s3    <= nx;
			ny_s3    <= ny;
			z_s3     <= zc;
		end
	end

	assign magx = nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
	assign magy = ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
	assign zlim = RW'(z_s3) << QW;

	always_ff @(posedge clk) begin
		if (adv) begin
			world_sd[0] <= world_s3;
			z_sd[0]     <= z_s3;
			remx_sd[0]  <= RW'(magx);
			remy_sd[0]  <= RW'(magy);
			qx_sd[0]    <= '0;
			qy_sd[0]    <= '0;
			negx_sd[0]  <= nx_s3[NW-1];
			negy_sd[0]  <= ny_s3[NW-1];
			ovfx_sd[0]  <= RW'(magx) >= zlim;
			ovfy_sd[0]  <= RW'(magy) >= zlim;
		end
	end

	genvar k;
	for (k = 0; k < QW; k++) begin : g_step
		localparam int SH = QW - 1 - k;
		logic [RW-1:0] dsh;
		logic          gex, gey;

		assign dsh = RW'(z_sd[k]) << SH;
		assign gex = remx_sd[k] >= dsh;
		assign gey = remy_sd[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_sd[k+1] <= '0;
			end else if (adv) begin
				flags_sd[k+1] <= flags_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				world_sd[k+1] <= world_sd[k];
				z_sd[k+1]     <= z_sd[k];
				remx_sd[k+1]  <= gex ? remx_sd[k] - dsh : remx_sd[k];
				remy_sd[k+1]  <= gey ? remy_sd[k] - dsh : remy_sd[k];
				qx_sd[k+1]    <= qx_sd[k] | (QW'(gex) << SH);
				qy_sd[k+1]    <= qy_sd[k] | (QW'(gey) << SH);
				negx_sd[k+1]  <= negx_sd[k];
				negy_sd[k+1]  <= negy_sd[k];
				ovfx_sd[k+1]  <= ovfx_sd[k];
				ovfy_sd[k+1]  <= ovfy_sd[k];
			end
		end
	end

	always_comb begin
		if (ovfx_sd[QW])
			scx = negx_sd[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
		else
			scx = negx_sd[QW] ? SW'(-{1'b0, qx_sd[QW]}) : {1'b0, qx_sd[QW]};
		if (ovfy_sd[QW])
			scy = negy_sd[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
		else
			scy = negy_sd[QW] ? SW'(-{1'b0, qy_sd[QW]}) : {1'b0, qy_sd[QW]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_o <= '0;
		end else if (adv) begin
			flags_o <= flags_sd[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flags_sd[QW].visible) begin
				wx_o <= world_sd[QW][C-1:0];
				wy_o <= world_sd[QW][2*C-1:C];
				wz_o <= world_sd[QW][3*C-1:2*C];
				sx_o <= scx;
				sy_o <= scy;
			end else begin
				wx_o <= '0;
				wy_o <= '0;
				wz_o <= '0;
				sx_o <= '0;
				sy_o <= '0;
			end
		end
	end
endmodule

/* hw/rtl/vertex_transform_and_project_unit.sv */
// Top level of the vertex transform and project unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input stream (s_t*): one vertex per request; tdata holds model_x, model_y,
//   model_z from the low bits up, tlast marks the last vertex of a mesh.
//   Output stream (m_t*): one result per vertex, in order; tdata holds world
//   x, y, z and screen x, y; tuser is the visible flag; tlast copies the mark.
//   Configuration: APB-style port, 64-bit registers at byte address 8*index;
//   write only while the pipeline is empty.
//   Pipeline: transform, distance multiply, one-bit-per-stage divider, output register.
//   Throughput: one vertex per cycle while the receiver keeps tready high.
//   Reset: all stages empty, registers take their reset values (identity
//   matrix, zero shift, distance 256, horizon 1000.0).
//   Stall: when the receiver holds tready low with a result waiting, every
//   stage holds and s_tready drops; no request is lost or repeated.
module vertex_transform_and_project_unit import vtp_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_W_DEF,
	parameter int COEF_WIDTH   = COEF_W_DEF,
	parameter int SCREEN_WIDTH = SCREEN_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// model_x, model_y, model_z
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// world_x, world_y, world_z, screen_x, screen_y
	output logic [((3*COORD_WIDTH+2*SCREEN_WIDTH+7)/8)*8-1:0] m_tdata,
	// visible
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int C        = COORD_WIDTH;
	localparam int SW       = SCREEN_WIDTH;
	localparam int OUT_BITS = 3 * C + 2 * SW;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	cfg_t          cfg;
	logic          adv;
	flags_t        flags_s2, flags_o;
	logic [C-1:0]  wx_s2, wy_s2, wz_s2, wx_o, wy_o, wz_o;
	logic [SW-1:0] sx_o, sy_o;

	assign adv      = !flags_o.valid || m_tready;
	assign s_tready = adv;

	vtp_regs #(.COEF_WIDTH(COEF_WIDTH)) u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	vtp_xform #(.COORD_WIDTH(C), .COEF_WIDTH(COEF_WIDTH)) u_xform (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(s_tvalid), .in_last(s_tlast),
		.mx(s_tdata[C-1:0]), .my(s_tdata[2*C-1:C]), .mz(s_tdata[3*C-1:2*C]),
		.cfg(cfg), .flags_s2(flags_s2), .wx_s2(wx_s2), .wy_s2(wy_s2), .wz_s2(wz_s2)
	);

	vtp_proj #(.COORD_WIDTH(C), .SCREEN_WIDTH(SW)) u_proj (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flags_in(flags_s2),
		.wx(wx_s2), .wy(wy_s2), .wz(wz_s2), .view_dist(cfg.view_dist),
		.flags_o(flags_o), .wx_o(wx_o), .wy_o(wy_o), .wz_o(wz_o), .sx_o(sx_o), .sy_o(sy_o)
	);

	assign m_tvalid = flags_o.valid;
	assign m_tuser  = flags_o.visible;
	assign m_tlast  = flags_o.last;
	assign m_tdata  = OUT_W'({sy_o, sx_o, wz_o, wy_o, wx_o});

	`ASSERT_IMPL(a_hidden_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
	`ASSERT_IMPL(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)
	`ASSERT_IMPL(a_zero_world_x, clk, arst_n, m_tvalid && wx_o == '0, sx_o == '0)
endmodule

/* dv/tb_vertex_transform_and_project_unit.sv */
// Self-checking testbench for the vertex transform and project unit.
`timescale 1ns / 1ps
module tb_vertex_transform_and_project_unit;
	import vtp_pkg::*;

	localparam int PIPE_LAT = 20;
	localparam int STALL_LIMIT = 3000;
	localparam longint NEAR_Q = 5 * 65536;

	typedef struct {
		logic [31:0] wx, wy, wz;
		logic [15:0] sx, sy;
		logic        vis, last;
	} vtx_res_t;

	class VertexScoreboard;
		logic [63:0] cfg [8];
		vtx_res_t    pending [$];
		int          errors, checked, seen_visible;

		function void load_reset();
			cfg[REG_ROW_X]    = 64'd65536;
			cfg[REG_ROW_Y]    = 64'd68719476736;
			cfg[REG_ROW_Z]    = 64'd72057594037927936;
			cfg[REG_SHIFT_XY] = '0;
			cfg[REG_SHIFT_Z]  = '0;
			cfg[REG_DIST]     = 64'd256;
			cfg[REG_FAR]      = 64'd65536000;
			cfg[REG_Z_OFF]    = '0;
		endfunction

		function longint sat(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			return (v > hi) ? hi : (v < lo) ? lo : v;
		endfunction

		function longint axis(logic [63:0] row, longint x, longint y, longint z,
			longint sh);
			longint c0, c1, c2, acc;
			c0 = $signed(row[19:0]);
			c1 = $signed(row[39:20]);
			c2 = $signed(row[59:40]);
			acc = c0 * x + c1 * y + c2 * z + (sh <<< 16);
			return sat(acc >>> 16, 32);
		endfunction

		function void note(logic [31:0] mx, my, mz, logic last);
			vtx_res_t r;
			longint x, y, z, ez, far_q, wx, wy, wz, zd, vdist;
			x = $signed(mx);
			y = $signed(my);
			z = $signed(mz);
			r = '{default: '0};
			r.last = last;
			ez = z + longint'($signed(cfg[REG_Z_OFF][31:0]));
			far_q = $signed(cfg[REG_FAR][31:0]);
			if (ez > NEAR_Q && ez <= far_q) begin
				wx = axis(cfg[REG_ROW_X], x, y, z, $signed(cfg[REG_SHIFT_XY][31:0]));
				wy = axis(cfg[REG_ROW_Y], x, y, z, $signed(cfg[REG_SHIFT_XY][63:32]));
				wz = axis(cfg[REG_ROW_Z], x, y, z, $signed(cfg[REG_SHIFT_Z][31:0]));
				zd = (wz <= 0) ? MIN_Z : wz;
				vdist = cfg[REG_DIST][11:0];
				r.wx = wx[31:0];
				r.wy = wy[31:0];
				r.wz = wz[31:0];
				r.sx = 16'(sat((vdist * wx) / zd, 16));
				r.sy = 16'(sat((vdist * wy) / zd, 16));
				r.vis = 1;
			end
			pending.push_back(r);
		endfunction

		function void check(vtx_res_t got);
			vtx_res_t e;
			checked++;
			if (got.vis) seen_visible++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h %h %h %h %h vis=%b", $time,
					got.wx, got.wy, got.wz, got.sx, got.sy, got.vis);
				return;
			end
			e = pending.pop_front();
			if (got.wx !== e.wx || got.wy !== e.wy || got.wz !== e.wz ||
				got.sx !== e.sx || got.sy !== e.sy || got.vis !== e.vis ||
				got.last !== e.last) begin
				errors++;
				$display("%0t: mismatch expected w=%h,%h,%h s=%h,%h vis=%b last=%b",
					$time, e.wx, e.wy, e.wz, e.sx, e.sy, e.vis, e.last);
				$display("%0t:          actual   w=%h,%h,%h s=%h,%h vis=%b last=%b",
					$time, got.wx, got.wy, got.wz, got.sx, got.sy, got.vis, got.last);
			end
		endfunction
	endclass

	logic         clk = 0, arst_n = 0;
	logic         s_tvalid = 0, s_tlast = 0, m_tready = 0;
	logic [95:0]  s_tdata = '0;
	logic         s_tready, m_tvalid, m_tuser, m_tlast, pready;
	logic [127:0] m_tdata;
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0, prdata;

	int send_idle = 0, recv_stall = 0, hold_token = 0, hold_seen = 0, hold_left = 0;
	int quiet = 0, sent = 0;
	VertexScoreboard sb;

	vertex_transform_and_project_unit dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= 300;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom % 100) >= recv_stall;
		end
	end

	always @(negedge clk) begin
		vtx_res_t got;
		if (m_tvalid && m_tready) begin
			got.wx = m_tdata[31:0];
			got.wy = m_tdata[63:32];
			got.wz = m_tdata[95:64];
			got.sx = m_tdata[111:96];
			got.sy = m_tdata[127:112];
			got.vis = m_tuser;
			got.last = m_tlast;
			sb.check(got);
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet = 0;
		else if (arst_n) quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_vertex(logic [31:0] x, y, z, logic last);
		while (($urandom % 100) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {z, y, x};
		s_tlast <= last;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		sb.note(x, y, z, last);
		sent++;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= CFG_ADDR_W'(8 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.cfg[idx] = (idx <= REG_ROW_Z) ? (val & 64'h0FFF_FFFF_FFFF_FFFF) :
			(idx == REG_DIST) ? (val & 64'hFFF) :
			(idx == REG_SHIFT_XY) ? val : (val & 64'hFFFF_FFFF);
	endtask

	function automatic logic [63:0] rand_row();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom % 2)
			for (int k = 0; k < 3; k++)
				v[k*20 +: 20] = $urandom_range(0, 262144) - 131072;
		return v;
	endfunction

	task automatic random_config();
		write_reg(REG_ROW_X, rand_row());
		write_reg(REG_ROW_Y, rand_row());
		write_reg(REG_ROW_Z, rand_row());
		write_reg(REG_SHIFT_XY, ($urandom % 2) ? {$urandom, $urandom} :
			{32'($urandom_range(0, 2000000) - 1000000), 32'($urandom_range(0, 2000000) - 1000000)});
		write_reg(REG_SHIFT_Z, ($urandom % 2) ? $urandom : $urandom_range(0, 20000000));
		write_reg(REG_DIST, $urandom_range(0, 4095));
		write_reg(REG_FAR, ($urandom % 4) ? $urandom_range(400000, 2000000000) : $urandom);
		write_reg(REG_Z_OFF, ($urandom % 2) ? $urandom : $urandom_range(0, 2000000) - 1000000);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom % 4)
			0: return $urandom;
			1: return {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
			default: return $urandom_range(0, 2000000) - 1000000;
		endcase
	endfunction

	function automatic logic [31:0] pick_z();
		longint off, far_q, ez, mz;
		off = $signed(sb.cfg[REG_Z_OFF][31:0]);
		far_q = $signed(sb.cfg[REG_FAR][31:0]);
		case ($urandom % 8)
			0: return $urandom;
			1: ez = NEAR_Q + $urandom_range(0, 1);
			2: ez = far_q + $urandom_range(0, 1);
			default: ez = NEAR_Q + 1 + longint'($urandom % 64'(
				(far_q > NEAR_Q + 1) ? ((far_q - NEAR_Q) > 32'hFFFFFFFF ?
				32'hFFFFFFFF : far_q - NEAR_Q) : 1));
		endcase
		mz = ez - off;
		if (mz > 2147483647) mz = 2147483647;
		if (mz < -2147483648) mz = -2147483648;
		return mz[31:0];
	endfunction

	task automatic run_phase(int n, int mode);
		send_idle = (mode == 1 || mode == 3) ? ((mode == 1) ? 50 : 22) : 0;
		recv_stall = (mode == 2 || mode == 3) ? ((mode == 2) ? 50 : 22) : 0;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3 && mode == 0) hold_token++;
			if (i == n / 2 && mode == 1) begin
				s_tvalid <= 0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end
			send_vertex(rand_coord(), rand_coord(), pick_z(), ($urandom % 8) == 0);
		end
		drain();
	endtask

	initial begin
		sb = new();
		sb.load_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd655360, 1);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'd655360, 0);
		send_vertex(32'd65536, 32'd65536, 32'(NEAR_Q), 0);
		send_vertex(32'd65536, 32'd65536, 32'(NEAR_Q + 1), 1);
		send_vertex(32'd65536, 32'd65536, 32'd65536000, 0);
		send_vertex(32'd65536, 32'd65536, 32'd65536001, 0);
		send_vertex(32'd0, 32'd0, 32'd0, 1);
		send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		send_vertex(32'h0000_0001, 32'hFFFF_0000, 32'd327681, 0);
		drain();

		write_reg(REG_ROW_Z, 64'h0FFF_FFFF_FFFF_FFFF);
		write_reg(REG_SHIFT_Z, 32'h8000_0000);
		write_reg(REG_Z_OFF, 32'h7FFF_FFFF);
		write_reg(REG_FAR, 32'h7FFF_FFFF);
		send_vertex(32'd65536, 32'hFFFF_0000, 32'h8000_0000, 0);
		send_vertex(32'h0001_0000, 32'd65536, 32'hFFFF_0000, 1);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_ROW_X, 64'd65536);
					write_reg(REG_ROW_Y, 64'd68719476736);
					write_reg(REG_ROW_Z, 64'd72057594037927936);
					write_reg(REG_SHIFT_Z, 0);
					write_reg(REG_FAR, 32'd65536000);
					write_reg(REG_Z_OFF, 0);
				end
				2: begin
					write_reg(REG_ROW_X, 64'h07FF_FF7F_FFF7_FFFF);
					write_reg(REG_ROW_Y, 64'h0800_0080_0008_0000);
					write_reg(REG_ROW_Z, 64'h07FF_FF7F_FFF7_FFFF);
					write_reg(REG_SHIFT_XY, 64'h8000_0000_7FFF_FFFF);
					write_reg(REG_SHIFT_Z, 32'h7FFF_FFFF);
					write_reg(REG_DIST, 12'd4095);
					write_reg(REG_FAR, 32'h7FFF_FFFF);
					write_reg(REG_Z_OFF, 32'h8000_0000);
				end
				3: begin
					write_reg(REG_DIST, 0);
					write_reg(REG_SHIFT_XY, 64'h7FFF_FFFF_8000_0000);
				end
				4: begin
					write_reg(REG_DIST, 12'd1);
					write_reg(REG_FAR, 0);
				end
				default: random_config();
			endcase
			run_phase((ph == 3 || ph == 4) ? 40 : 110, ph % 4);
		end

		$display("Sent %0d vertices, checked %0d results, %0d of them visible.",
			sent, sb.checked, sb.seen_visible);
		$display("Covered identity, extreme and random matrices, hidden bands and stalls.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_regs.sv
hw/rtl/vtp_xform.sv
hw/rtl/vtp_proj.sv
hw/rtl/vertex_transform_and_project_unit.sv
dv/tb_vertex_transform_and_project_unit.sv
